### design/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared constants, codes and types of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

   localparam int NODE_CAPACITY    = 256;
   localparam int NODE_BITS        = $clog2(NODE_CAPACITY);
   localparam int NCOUNT_BITS      = NODE_BITS + 1;
   localparam int PATTERN_CAPACITY = 32;
   localparam int PAT_BITS         = 5;
   localparam int PCOUNT_BITS      = PAT_BITS + 1;
   localparam int POS_BITS         = 16;
   localparam int CHAR_BITS        = 8;
   localparam int ALPHABET_SIZE    = 256;
   localparam int GOTO_DEPTH       = NODE_CAPACITY * ALPHABET_SIZE;
   localparam int GOTO_ABITS       = NODE_BITS + CHAR_BITS;
   localparam int GOTO_WIDTH       = NODE_BITS + 1;
   localparam int MAX_RESULTS      = 32;
   localparam int HIT_BITS         = 6;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_BUILD = 2'd1;
   localparam logic [1:0] ACT_SCAN  = 2'd2;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_HIT   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BUILT     = 2'd1;
   localparam logic [1:0] ST_NODE_FULL = 2'd2;
   localparam logic [1:0] ST_PAT_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic [CHAR_BITS-1:0] data_byte;
      logic                 pattern_end;
      logic                 buffer_start;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          status;
      logic [PAT_BITS-1:0] id;
      logic [POS_BITS-1:0] pos;
      logic                last;
   } res_type;

endpackage

### design/multi_pattern_byte_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Aho-Corasick matcher: trie insert, breadth-first automaton build, scan.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall action, data_byte, pattern_end,
//                                     buffer_start
//   rsp      out  rsp_valid/rsp_stall result_kind, status, pattern_id,
//                                     end_position, run_last
//
// Steps: an add byte reads the goto table and may write a new edge; its last
//   byte then files the pattern id. A scan byte reads the goto table, then walks
//   the fail chain and emits each hit. A build is bound by the single goto port.
// Reset: a clearing pass wipes the goto table; req_stall is
//   high throughout.
// Stalls: a two-item queue parts the front from the engine; the result
//   register lets the engine find the next hit while one waits.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_pattern_end,
   input  logic        req_buffer_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_pattern_id,
   output logic [15:0] rsp_end_position,
   output logic        rsp_run_last
);
   import mpbm_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    clear_busy;
   logic    out_free;
   logic    out_load;
   res_type out_res;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff;

   mpbm_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_data_byte(req_data_byte),
      .req_pattern_end(req_pattern_end), .req_buffer_start(req_buffer_start),
      .clear_busy(clear_busy), .cmd_pop(cmd_pop),
      .cmd_valid(cmd_valid), .cmd(cmd));

   mpbm_engine u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .clear_busy(clear_busy), .out_free(out_free),
      .out_load(out_load), .out_res(out_res));

   // free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_ff <= out_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.kind;
   assign rsp_status       = rsp_ff.status;
   assign rsp_pattern_id   = rsp_ff.id;
   assign rsp_end_position = rsp_ff.pos;
   assign rsp_run_last     = rsp_ff.last;

   // a hit always carries status ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_HIT)) |-> (rsp_status == ST_OK))
      else $error("hit with non-ok status");

   // add and build results carry no position and end their item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_HIT)) |->
      ((rsp_end_position == '0) && rsp_run_last))
      else $error("status result malformed");

   // clearing pass holds off requests straight after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

endmodule

### design/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/mpbm_front.sv
// ----------------------------------------------------------------------------
// mpbm_front
// Accepts request items, drops unused action codes, queues two deep.
// ----------------------------------------------------------------------------
module mpbm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_pattern_end,
   input  logic                      req_buffer_start,
   input  logic                      clear_busy,
   input  logic                      cmd_pop,
   output logic                      cmd_valid,
   output mpbm_pkg::cmd_type         cmd
);
   import mpbm_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2) || clear_busy;
   // unused action code: taken and dropped
   assign push = req_valid && !req_stall &&
                 ((req_action == ACT_ADD) || (req_action == ACT_BUILD) ||
                  (req_action == ACT_SCAN));

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{action: req_action, data_byte: req_data_byte,
                                 pattern_end: req_pattern_end,
                                 buffer_start: req_buffer_start};
      end
   end

endmodule

### design/mpbm_engine.sv
// ----------------------------------------------------------------------------
// mpbm_engine
// Back end: trie insert, breadth-first build, scan and fail-chain hit walk.
// ----------------------------------------------------------------------------
module mpbm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mpbm_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              clear_busy,
   input  logic              out_free,
   output logic              out_load,
   output mpbm_pkg::res_type out_res
);
   import mpbm_pkg::*;

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ADD_RD   = 5'd2;
   localparam logic [4:0] S_ADD_WAIT = 5'd3;
   localparam logic [4:0] S_ADD_DONE = 5'd4;
   localparam logic [4:0] S_BR_RD    = 5'd5;
   localparam logic [4:0] S_BR_ACT   = 5'd6;
   localparam logic [4:0] S_B_POP    = 5'd7;
   localparam logic [4:0] S_B_POPW   = 5'd8;
   localparam logic [4:0] S_B_FW     = 5'd9;
   localparam logic [4:0] S_B_RD1    = 5'd10;
   localparam logic [4:0] S_B_RD2    = 5'd11;
   localparam logic [4:0] S_B_ACT    = 5'd12;
   localparam logic [4:0] S_SC_RD    = 5'd13;
   localparam logic [4:0] S_H_NODE   = 5'd14;
   localparam logic [4:0] S_H_SEL    = 5'd15;
   localparam logic [4:0] S_H_EMIT   = 5'd16;
   localparam logic [4:0] S_H_FIN    = 5'd17;

   localparam logic [POS_BITS-1:0]   POS_MAX = '1;
   localparam logic [GOTO_ABITS-1:0] CLR_END = '1;

   logic [4:0]             state_ff, state_in;
   logic [GOTO_ABITS-1:0]  clr_ff, clr_in;
   logic                   built_ff, built_in;
   logic [NODE_BITS-1:0]   cursor_ff, cursor_in;
   logic                   err_ff, err_in;
   logic [NCOUNT_BITS-1:0] ncount_ff, ncount_in;
   logic [PCOUNT_BITS-1:0] pcount_ff, pcount_in;
   logic [NODE_BITS-1:0]   scan_node_ff, scan_node_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [CHAR_BITS-1:0]   byte_ff, byte_in;
   logic                   end_ff, end_in;
   logic [CHAR_BITS-1:0]   chr_ff, chr_in;
   logic [NCOUNT_BITS-1:0] head_ff, head_in;
   logic [NCOUNT_BITS-1:0] tail_ff, tail_in;
   logic [NODE_BITS-1:0]   u_ff, u_in;
   logic [NODE_BITS-1:0]   f_ff, f_in;
   logic [NODE_BITS-1:0]   via_ff, via_in;
   logic [NODE_BITS-1:0]   walk_ff, walk_in;
   logic [PAT_BITS-1:0]    p_ff, p_in;
   logic [HIT_BITS-1:0]    nhit_ff, nhit_in;
   logic                   pend_valid_ff, pend_valid_in;
   res_type                pend_ff, pend_in;

   logic                   has_ff [NODE_CAPACITY];
   logic                   has_next_ff [PATTERN_CAPACITY];
   logic [PAT_BITS-1:0]    next_ff [PATTERN_CAPACITY];
   logic                   has_set;
   logic                   alloc;
   logic                   link_set;

   // memories
   logic                   g_we;
   logic [GOTO_ABITS-1:0]  g_waddr, g_raddr;
   logic [GOTO_WIDTH-1:0]  g_wdata, g_rdata;
   logic                   fl_we;
   logic [NODE_BITS-1:0]   fl_waddr, fl_raddr, fl_wdata, fl_rdata;
   logic                   q_we;
   logic [NODE_BITS-1:0]   q_wdata, q_rdata;
   logic                   fp_we, lp_we;
   logic [PAT_BITS-1:0]    fp_rdata, lp_rdata;
   logic [PAT_BITS-1:0]    new_id;

   mpbm_ram #(.WIDTH(GOTO_WIDTH), .DEPTH(GOTO_DEPTH)) u_goto (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rdata));
   mpbm_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_CAPACITY)) u_fail (
      .clock(clock), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
      .raddr(fl_raddr), .rdata(fl_rdata));
   mpbm_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_CAPACITY)) u_queue (
      .clock(clock), .we(q_we), .waddr(tail_ff[NODE_BITS-1:0]), .wdata(q_wdata),
      .raddr(head_ff[NODE_BITS-1:0]), .rdata(q_rdata));
   mpbm_ram #(.WIDTH(PAT_BITS), .DEPTH(NODE_CAPACITY)) u_first (
      .clock(clock), .we(fp_we), .waddr(cursor_ff), .wdata(new_id),
      .raddr(walk_ff), .rdata(fp_rdata));
   mpbm_ram #(.WIDTH(PAT_BITS), .DEPTH(NODE_CAPACITY)) u_last (
      .clock(clock), .we(lp_we), .waddr(cursor_ff), .wdata(new_id),
      .raddr(cursor_ff), .rdata(lp_rdata));

   assign new_id     = pcount_ff[PAT_BITS-1:0];
   assign clear_busy = (state_ff == S_CLEAR);
   assign fl_raddr   = (state_ff == S_B_POPW) ? q_rdata : walk_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      built_in      = built_ff;
      cursor_in     = cursor_ff;
      err_in        = err_ff;
      ncount_in     = ncount_ff;
      pcount_in     = pcount_ff;
      scan_node_in  = scan_node_ff;
      pos_in        = pos_ff;
      byte_in       = byte_ff;
      end_in        = end_ff;
      chr_in        = chr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      u_in          = u_ff;
      f_in          = f_ff;
      via_in        = via_ff;
      walk_in       = walk_ff;
      p_in          = p_ff;
      nhit_in       = nhit_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      cmd_pop       = 1'b0;
      g_we          = 1'b0;
      g_waddr       = {u_ff, chr_ff};
      g_wdata       = '0;
      g_raddr       = {cursor_ff, byte_ff};
      fl_we         = 1'b0;
      fl_waddr      = g_rdata[NODE_BITS-1:0];
      fl_wdata      = via_ff;
      q_we          = 1'b0;
      q_wdata       = g_rdata[NODE_BITS-1:0];
      fp_we         = 1'b0;
      lp_we         = 1'b0;
      has_set       = 1'b0;
      alloc         = 1'b0;
      link_set      = 1'b0;
      out_load      = 1'b0;
      out_res       = pend_ff;
      out_res.last  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CLR_END) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               byte_in = cmd.data_byte;
               end_in  = cmd.pattern_end;
               case (cmd.action)
                  ACT_ADD: begin
                     if (!built_ff && !err_ff) begin
                        g_raddr  = {cursor_ff, cmd.data_byte};
                        state_in = S_ADD_RD;
                     end else if (cmd.pattern_end) begin
                        state_in = S_ADD_WAIT;
                     end
                  end
                  ACT_BUILD: begin
                     if (built_ff) begin
                        pend_in       = '{kind: KIND_BUILD, status: ST_BUILT,
                                          id: '0, pos: '0, last: 1'b0};
                        pend_valid_in = 1'b1;
                        state_in      = S_H_FIN;
                     end else begin
                        chr_in   = '0;
                        head_in  = '0;
                        tail_in  = '0;
                        state_in = S_BR_RD;
                     end
                  end
                  ACT_SCAN: begin
                     if (built_ff) begin
                        if (cmd.buffer_start) begin
                           pos_in  = {{(POS_BITS-1){1'b0}}, 1'b1};
                           g_raddr = {{NODE_BITS{1'b0}}, cmd.data_byte};
                        end else begin
                           pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
                           g_raddr = {scan_node_ff, cmd.data_byte};
                        end
                        state_in = S_SC_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            if (g_rdata[NODE_BITS]) begin
               cursor_in = g_rdata[NODE_BITS-1:0];
            end else if (ncount_ff < NCOUNT_BITS'(NODE_CAPACITY)) begin
               g_we      = 1'b1;
               g_waddr   = {cursor_ff, byte_ff};
               g_wdata   = {1'b1, ncount_ff[NODE_BITS-1:0]};
               cursor_in = ncount_ff[NODE_BITS-1:0];
               ncount_in = ncount_ff + 1'b1;
            end else begin
               err_in = 1'b1;
            end
            state_in = end_ff ? S_ADD_WAIT : S_IDLE;
         end
         S_ADD_WAIT: begin
            state_in = S_ADD_DONE;
         end
         S_ADD_DONE: begin
            pend_in = '{kind: KIND_ADD, status: ST_OK, id: '0, pos: '0, last: 1'b0};
            if (built_ff) begin
               pend_in.status = ST_BUILT;
            end else if (err_ff) begin
               pend_in.status = ST_NODE_FULL;
            end else if (pcount_ff >= PCOUNT_BITS'(PATTERN_CAPACITY)) begin
               pend_in.status = ST_PAT_FULL;
            end else begin
               pend_in.id = new_id;
               pcount_in  = pcount_ff + 1'b1;
               alloc      = 1'b1;
               lp_we      = 1'b1;
               if (!has_ff[cursor_ff]) begin
                  fp_we   = 1'b1;
                  has_set = 1'b1;
               end else begin
                  link_set = 1'b1;
               end
            end
            cursor_in     = '0;
            err_in        = 1'b0;
            pend_valid_in = 1'b1;
            state_in      = S_H_FIN;
         end
         S_BR_RD: begin
            g_raddr  = {{NODE_BITS{1'b0}}, chr_ff};
            state_in = S_BR_ACT;
         end
         S_BR_ACT: begin
            if (g_rdata[NODE_BITS]) begin
               fl_we    = 1'b1;
               fl_wdata = '0;
               if (!tail_ff[NODE_BITS]) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we    = 1'b1;
               g_waddr = {{NODE_BITS{1'b0}}, chr_ff};
               g_wdata = {1'b1, {NODE_BITS{1'b0}}};
            end
            chr_in   = chr_ff + 1'b1;
            state_in = (chr_ff == '1) ? S_B_POP : S_BR_RD;
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               built_in      = 1'b1;
               pend_in       = '{kind: KIND_BUILD, status: ST_OK,
                                 id: '0, pos: '0, last: 1'b0};
               pend_valid_in = 1'b1;
               state_in      = S_H_FIN;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = S_B_POPW;
            end
         end
         S_B_POPW: begin
            u_in     = q_rdata;
            state_in = S_B_FW;
         end
         S_B_FW: begin
            f_in     = fl_rdata;
            chr_in   = '0;
            state_in = S_B_RD1;
         end
         S_B_RD1: begin
            g_raddr  = {f_ff, chr_ff};
            state_in = S_B_RD2;
         end
         S_B_RD2: begin
            via_in   = g_rdata[NODE_BITS] ? g_rdata[NODE_BITS-1:0] : '0;
            g_raddr  = {u_ff, chr_ff};
            state_in = S_B_ACT;
         end
         S_B_ACT: begin
            if (g_rdata[NODE_BITS]) begin
               fl_we = 1'b1;
               if (!tail_ff[NODE_BITS]) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we    = 1'b1;
               g_waddr = {u_ff, chr_ff};
               g_wdata = {1'b1, via_ff};
            end
            chr_in   = chr_ff + 1'b1;
            state_in = (chr_ff == '1) ? S_B_POP : S_B_RD1;
         end
         S_SC_RD: begin
            scan_node_in  = g_rdata[NODE_BITS] ? g_rdata[NODE_BITS-1:0] : '0;
            walk_in       = g_rdata[NODE_BITS] ? g_rdata[NODE_BITS-1:0] : '0;
            nhit_in       = '0;
            pend_valid_in = 1'b0;
            state_in      = S_H_NODE;
         end
         S_H_NODE: begin
            state_in = S_H_SEL;
         end
         S_H_SEL: begin
            if (has_ff[walk_ff]) begin
               p_in     = fp_rdata;
               state_in = S_H_EMIT;
            end else if (walk_ff == '0) begin
               state_in = S_H_FIN;
            end else begin
               walk_in  = fl_rdata;
               state_in = S_H_NODE;
            end
         end
         S_H_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               out_load      = pend_valid_ff;
               pend_in       = '{kind: KIND_HIT, status: ST_OK, id: p_ff,
                                 pos: pos_ff, last: 1'b0};
               pend_valid_in = 1'b1;
               nhit_in       = nhit_ff + 1'b1;
               if (nhit_ff == HIT_BITS'(MAX_RESULTS - 1)) begin
                  state_in = S_H_FIN;
               end else if (has_next_ff[p_ff]) begin
                  p_in = next_ff[p_ff];
               end else if (walk_ff == '0) begin
                  state_in = S_H_FIN;
               end else begin
                  walk_in  = fl_rdata;
                  state_in = S_H_NODE;
               end
            end
         end
         S_H_FIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_res.last  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         built_ff      <= 1'b0;
         cursor_ff     <= '0;
         err_ff        <= 1'b0;
         ncount_ff     <= NCOUNT_BITS'(1);
         pcount_ff     <= '0;
         scan_node_ff  <= '0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < NODE_CAPACITY; i++) begin
            has_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         built_ff      <= built_in;
         cursor_ff     <= cursor_in;
         err_ff        <= err_in;
         ncount_ff     <= ncount_in;
         pcount_ff     <= pcount_in;
         scan_node_ff  <= scan_node_in;
         pos_ff        <= pos_in;
         pend_valid_ff <= pend_valid_in;
         if (has_set) begin
            has_ff[cursor_ff] <= 1'b1;
         end
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
      chr_ff  <= chr_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      u_ff    <= u_in;
      f_ff    <= f_in;
      via_ff  <= via_in;
      walk_ff <= walk_in;
      p_ff    <= p_in;
      nhit_ff <= nhit_in;
      pend_ff <= pend_in;
      if (alloc) begin
         has_next_ff[new_id] <= 1'b0;
      end
      if (link_set) begin
         has_next_ff[lp_rdata] <= 1'b1;
         next_ff[lp_rdata]     <= new_id;
      end
   end

endmodule

### verif/tb_multi_pattern_byte_matcher.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_byte_matcher
// Self-checking bench: builds a small pattern dictionary, overflows the
// pattern store, builds the automaton and scans directed and random
// bytes, checking every add, build and hit result against a behavioural
// model of the trie, failure links and fail-chain hit walk.
// ----------------------------------------------------------------------------
module tb_multi_pattern_byte_matcher;
   timeunit 1ns;
   timeprecision 1ps;
   import mpbm_pkg::*;

   localparam int POS_MAX     = (1 << POS_BITS) - 1;
   localparam int CALM_FROM   = 70000;   // idle-free stretch, in cycles
   localparam int CALM_TO     = 90000;
   localparam int HOLD_CYCLES = 400;     // one long receiver hold-off
   localparam int N_SHORT     = 12;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_ADD;
   logic [7:0]  req_data_byte = '0;
   logic        req_pattern_end = 1'b0;
   logic        req_buffer_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_pattern_id;
   logic [15:0] rsp_end_position;
   logic        rsp_run_last;

   multi_pattern_byte_matcher dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Matcher model: trie, failure links, per-node pattern lists
   // ---------------------------------------------------------------------
   int  goto_dst [GOTO_DEPTH];
   bit  goto_ok  [GOTO_DEPTH];
   int  fail_to  [NODE_CAPACITY];
   int  first_pat[NODE_CAPACITY];
   bit  has_pat  [NODE_CAPACITY];
   int  next_pat [PATTERN_CAPACITY];
   bit  has_next [PATTERN_CAPACITY];
   int  n_nodes = 1, n_pats = 0, cursor = 0, ins_err = 0, scan_at = 0, scan_pos = 0;
   bit  built = 1'b0;

   res_type results_due[$];
   cmd_type items_pending[$];
   bit      failed = 1'b0;
   int      cyc = 0;

   function automatic res_type mk(logic [1:0] k, logic [1:0] s, int id, int pos);
      res_type r;
      r.kind = k; r.status = s; r.id = id[PAT_BITS-1:0]; r.pos = pos[POS_BITS-1:0];
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void build_automaton();
      int bq[$];
      int u, f, e, fe, via, v;
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
         if (goto_ok[c]) begin
            fail_to[goto_dst[c]] = 0;
            bq = {bq, goto_dst[c]};
         end else begin
            goto_dst[c] = 0; goto_ok[c] = 1'b1;
         end
      end
      while (bq.size() > 0) begin
         u = bq.pop_front();
         f = fail_to[u];
         for (int c = 0; c < ALPHABET_SIZE; c++) begin
            e = u * ALPHABET_SIZE + c;
            fe = f * ALPHABET_SIZE + c;
            via = goto_ok[fe] ? goto_dst[fe] : 0;
            if (goto_ok[e]) begin
               v = goto_dst[e];
               fail_to[v] = via;
               bq = {bq, v};
            end else begin
               goto_dst[e] = via; goto_ok[e] = 1'b1;
            end
         end
      end
      built = 1'b1;
   endfunction

   // works out every result an accepted item causes and queues them
   function automatic void predict_item(cmd_type c);
      res_type outs[$];
      int e, st, id, p, node, hops, guard;
      if (c.action == ACT_ADD) begin
         if (!built && ins_err == 0) begin
            e = cursor * ALPHABET_SIZE + c.data_byte;
            if (goto_ok[e]) cursor = goto_dst[e];
            else if (n_nodes < NODE_CAPACITY) begin
               goto_dst[e] = n_nodes; goto_ok[e] = 1'b1;
               cursor = n_nodes; n_nodes++;
            end else ins_err = ST_NODE_FULL;
         end
         if (c.pattern_end) begin
            st = ST_OK; id = 0;
            if (built) st = ST_BUILT;
            else if (ins_err != 0) st = ins_err;
            else if (n_pats >= PATTERN_CAPACITY) st = ST_PAT_FULL;
            else begin
               id = n_pats++;
               has_next[id] = 1'b0;
               if (!has_pat[cursor]) begin
                  first_pat[cursor] = id; has_pat[cursor] = 1'b1;
               end else begin
                  p = first_pat[cursor];
                  while (has_next[p]) p = next_pat[p];
                  next_pat[p] = id; has_next[p] = 1'b1;
               end
            end
            cursor = 0; ins_err = 0;
            outs = {outs, mk(KIND_ADD, 2'(st), id, 0)};
         end
      end else if (c.action == ACT_BUILD) begin
         if (built) outs = {outs, mk(KIND_BUILD, ST_BUILT, 0, 0)};
         else begin
            build_automaton();
            outs = {outs, mk(KIND_BUILD, ST_OK, 0, 0)};
         end
      end else if (c.action == ACT_SCAN && built) begin
         if (c.buffer_start) begin
            scan_at = 0; scan_pos = 0;
         end
         if (scan_pos < POS_MAX) scan_pos++;
         e = scan_at * ALPHABET_SIZE + c.data_byte;
         scan_at = goto_ok[e] ? goto_dst[e] : 0;
         node = scan_at; hops = 0;
         // hits: own list in add order, then down the fail chain to root
         while (hops <= NODE_CAPACITY) begin
            if (has_pat[node]) begin
               p = first_pat[node]; guard = 0;
               while (outs.size() < MAX_RESULTS && guard < PATTERN_CAPACITY) begin
                  outs = {outs, mk(KIND_HIT, ST_OK, p, scan_pos)};
                  if (!has_next[p]) break;
                  p = next_pat[p]; guard++;
               end
            end
            if (node == 0 || outs.size() >= MAX_RESULTS) break;
            node = fail_to[node]; hops++;
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) results_due = {results_due, outs[i]};
   endfunction

   // ---------------------------------------------------------------------
   // Driver: feeds items from the pending queue, idles now and then
   // ---------------------------------------------------------------------
   wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            predict_item({req_action, req_data_byte, req_pattern_end, req_buffer_start});
         if (items_pending.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
            cmd_type c;
            c = items_pending.pop_front();
            req_valid        <= 1'b1;
            req_action       <= c.action;
            req_data_byte    <= c.data_byte;
            req_pattern_end  <= c.pattern_end;
            req_buffer_start <= c.buffer_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random stall, one long hold-off on the first hit, compare
   // ---------------------------------------------------------------------
   int hold_left = 0;
   bit held_once = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result kind %0d id %0d pos %0d", $time,
                        rsp_result_kind, rsp_pattern_id, rsp_end_position);
               failed = 1'b1;
            end else begin
               res_type x;
               x = results_due.pop_front();
               if (rsp_result_kind !== x.kind) begin
                  $display("%0t: kind exp %0d got %0d", $time, x.kind, rsp_result_kind);
                  failed = 1'b1;
               end
               if (rsp_status !== x.status) begin
                  $display("%0t: status exp %0d got %0d", $time, x.status, rsp_status);
                  failed = 1'b1;
               end
               if (rsp_pattern_id !== x.id) begin
                  $display("%0t: pattern id exp %0d got %0d", $time, x.id, rsp_pattern_id);
                  failed = 1'b1;
               end
               if (rsp_end_position !== x.pos) begin
                  $display("%0t: end position exp %0d got %0d", $time, x.pos,
                           rsp_end_position);
                  failed = 1'b1;
               end
               if (rsp_run_last !== x.last) begin
                  $display("%0t: run last exp %0d got %0d", $time, x.last, rsp_run_last);
                  failed = 1'b1;
               end
               if (x.kind == KIND_HIT && !held_once) begin
                  held_once = 1'b1;
                  hold_left = HOLD_CYCLES;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 7);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic [7:0] sym [4] = '{8'h00, 8'hff, 8'h5a, 8'ha5};
   // short dictionary over sym[]: suffix overlaps and a duplicate
   int short_len [N_SHORT] = '{1, 2, 2, 3, 4, 2, 3, 1, 4, 3, 2, 1};
   int short_sym [N_SHORT][4] = '{
      '{0,0,0,0}, '{1,0,0,0}, '{0,1,0,0}, '{2,0,1,0}, '{2,3,2,3}, '{3,2,0,0},
      '{1,0,1,0}, '{0,0,0,0}, '{0,0,0,0}, '{3,2,3,0}, '{2,3,0,0}, '{3,0,0,0}};

   task automatic put_item(logic [1:0] act, logic [7:0] b, logic pe, logic bs);
      cmd_type c;
      c.action = act; c.data_byte = b; c.pattern_end = pe; c.buffer_start = bs;
      items_pending = {items_pending, c};
   endtask

   task automatic put_short(int k);
      for (int j = 0; j < short_len[k]; j++)
         put_item(ACT_ADD, sym[short_sym[k][j]], j == short_len[k] - 1,
                  1'($urandom_range(1)));
   endtask

   task automatic put_scan(logic [7:0] b, logic bs);
      put_item(ACT_SCAN, b, 1'($urandom_range(1)), bs);
   endtask

   initial begin
      int r;
      // scans and an unused code before anything is built: no result
      put_scan(8'h00, 1'b1);
      put_scan(8'hff, 1'b0);
      put_item(ACT_UNUSED, 8'hff, 1'b1, 1'b1);
      for (int k = 0; k < N_SHORT; k++) put_short(k);
      // repeats of known patterns reuse nodes until ids run out, a few past
      for (int k = 0; k < PATTERN_CAPACITY - N_SHORT + 4; k++) put_short(k % N_SHORT);
      // unfinished pattern left hanging at build time
      put_item(ACT_ADD, sym[2], 1'b0, 1'b0);
      put_item(ACT_BUILD, 8'h00, 1'b0, 1'b0);
      put_item(ACT_BUILD, 8'hff, 1'b1, 1'b1);
      put_item(ACT_ADD, 8'h00, 1'b0, 1'b0);
      put_item(ACT_ADD, 8'hff, 1'b1, 1'b0);
      // dense hits: the single-byte duplicates stack up into multi-hit bursts
      put_scan(8'h00, 1'b1);
      put_scan(8'h00, 1'b0);
      put_scan(8'hff, 1'b0);
      put_scan(8'h00, 1'b0);
      put_scan(8'h5a, 1'b1);
      put_scan(8'ha5, 1'b0);
      put_scan(8'h5a, 1'b0);
      put_scan(8'ha5, 1'b0);
      put_item(ACT_UNUSED, 8'h00, 1'b0, 1'b0);

      // random part, mostly scans over the dictionary alphabet
      for (int i = 0; i < 120; i++) begin
         r = $urandom_range(99);
         if (r < 60)      put_scan(sym[$urandom_range(3)], $urandom_range(9) == 0);
         else if (r < 80) put_scan(8'($urandom_range(255)), $urandom_range(9) == 0);
         else if (r < 92) put_item(ACT_ADD, 8'($urandom_range(255)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
         else if (r < 96) put_item(ACT_BUILD, 8'($urandom_range(255)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
         else             put_item(ACT_UNUSED, 8'($urandom_range(255)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (items_pending.size() > 0 || req_valid) @(posedge clock);
      while (results_due.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (!failed && results_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
